// ----- src/cpu8_pkg.sv -----
// Shared types, opcode field codes and a helper function for the 8-bit ALU execute core.
package cpu8_pkg;

  localparam int unsigned DataW = 8;

  typedef logic [DataW-1:0] byte_t;

  // low two bits of the opcode
  typedef enum logic [1:0] {
    GRP_0 = 2'b00,
    GRP_1 = 2'b01,
    GRP_2 = 2'b10,
    GRP_3 = 2'b11
  } grp_t;

  // group-1 operations, opcode bits 7:5
  localparam logic [2:0] G1_ORA = 3'd0;
  localparam logic [2:0] G1_AND = 3'd1;
  localparam logic [2:0] G1_EOR = 3'd2;
  localparam logic [2:0] G1_ADC = 3'd3;
  localparam logic [2:0] G1_STA = 3'd4;
  localparam logic [2:0] G1_LDA = 3'd5;
  localparam logic [2:0] G1_CMP = 3'd6;
  localparam logic [2:0] G1_SBC = 3'd7;

  // group-2 operations, opcode bits 7:5
  localparam logic [2:0] G2_ASL = 3'd0;
  localparam logic [2:0] G2_ROL = 3'd1;
  localparam logic [2:0] G2_LSR = 3'd2;
  localparam logic [2:0] G2_ROR = 3'd3;
  localparam logic [2:0] G2_STX = 3'd4;
  localparam logic [2:0] G2_LDX = 3'd5;
  localparam logic [2:0] G2_DEC = 3'd6;
  localparam logic [2:0] G2_INC = 3'd7;

  // addressing modes, opcode bits 4:2
  localparam logic [2:0] MODE_G1_IMM  = 3'd2;
  localparam logic [2:0] MODE_G2_IMM  = 3'd0;
  localparam logic [2:0] MODE_G2_ACC  = 3'd2;
  localparam logic [2:0] MODE_G2_BADA = 3'd4;
  localparam logic [2:0] MODE_G2_BADB = 3'd6;

  localparam logic [DataW-1:0] SignBit = 8'h80;

  // architectural registers and flags
  typedef struct packed {
    byte_t acc;
    byte_t xreg;
    logic  n;
    logic  v;
    logic  z;
    logic  c;
  } arch_t;

  // one result beat
  typedef struct packed {
    logic  recognized;
    logic  write_enable;
    byte_t write_data;
    byte_t acc;
    byte_t xreg;
    logic [3:0] flags;
  } res_t;

  // shift or rotate one byte; returns {carry out, result}
  function automatic logic [DataW:0] shift_byte(input logic [2:0] kind, input byte_t v,
                                                input logic cin);
    logic [DataW:0] r;
    r = '0;
    case (kind)
      G2_ASL:  r = {v[DataW-1], v[DataW-2:0], 1'b0};
      G2_ROL:  r = {v[DataW-1], v[DataW-2:0], cin};
      G2_LSR:  r = {v[0], 1'b0, v[DataW-1:1]};
      default: r = {v[0], cin, v[DataW-1:1]};
    endcase
    return r;
  endfunction

endpackage

// ----- src/cpu8_alu_execute_core.sv -----
// Top level of the 8-bit ALU execute core: input register, state, ALU and result register.
// One instruction beat enters per cycle unless in_stall is high; its result beat leaves
// through the input register, then the result register. The ALU reads A, X and the flags
// and commits the new values in the same cycle that it loads the result, so back-to-back
// instructions see each other's effects with no bubble. A stall on the output holds
// the result register and, behind it, the input register; the input side stalls only
// when both are full. Group-1 and group-2 opcodes execute in binary; any other code,
// STA immediate and the illegal group-2 modes return recognized low and change nothing.
module cpu_8bit_alu_execute_core import cpu8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] opcode,
  input  logic [7:0] mem_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       recognized,
  output logic       write_enable,
  output logic [7:0] write_data,
  output logic [7:0] acc_out,
  output logic [7:0] xreg_out,
  output logic [3:0] flags_out
);

  logic       s_valid;
  logic [7:0] s_opcode;
  byte_t      s_mem;
  logic       out_full;
  logic       advance;
  arch_t      state;
  arch_t      state_next;
  res_t       alu_res;
  res_t       out_data;

  assign advance  = s_valid & ~out_full;
  assign in_stall = s_valid & out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_opcode <= opcode;
      s_mem    <= mem_data;
    end
  end

  // commit architectural state with the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  cpu8_alu u_alu (
    .opcode   (s_opcode),
    .mem_data (s_mem),
    .cur      (state),
    .nxt      (state_next),
    .res      (alu_res)
  );

  cpu8_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (alu_res),
    .full      (out_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (out_data)
  );

  assign recognized   = out_data.recognized;
  assign write_enable = out_data.write_enable;
  assign write_data   = out_data.write_data;
  assign acc_out      = out_data.acc;
  assign xreg_out     = out_data.xreg;
  assign flags_out    = out_data.flags;

endmodule

// ----- src/cpu8_alu.sv -----
// Decode and execute of one group-1 or group-2 instruction against the current state.
module cpu8_alu import cpu8_pkg::*; (
  input  logic [7:0] opcode,
  input  byte_t      mem_data,
  input  arch_t      cur,
  output arch_t      nxt,
  output res_t       res
);

  logic [1:0]     grp;
  logic [2:0]     mode;
  logic [2:0]     op;
  logic           ok;
  logic           we;
  byte_t          wd;
  logic [DataW:0] sum;
  logic [DataW:0] diff;
  logic [DataW:0] sbc;
  logic [DataW:0] shm;
  logic [DataW:0] sha;
  byte_t          dec_v;
  byte_t          inc_v;

  assign grp  = opcode[1:0];
  assign mode = opcode[4:2];
  assign op   = opcode[7:5];

  assign sum   = {1'b0, cur.acc} + {1'b0, mem_data} + {{DataW{1'b0}}, cur.c};
  assign diff  = {1'b0, cur.acc} - {1'b0, mem_data};
  assign sbc   = {1'b0, cur.acc} - {1'b0, mem_data} - {{DataW{1'b0}}, ~cur.c};
  assign shm   = shift_byte(op, mem_data, cur.c);
  assign sha   = shift_byte(op, cur.acc, cur.c);
  assign dec_v = mem_data - byte_t'(1);
  assign inc_v = mem_data + byte_t'(1);

  always_comb begin
    nxt = cur;
    ok  = 1'b0;
    we  = 1'b0;
    wd  = '0;
    if (grp == GRP_1) begin
      ok = 1'b1;
      unique case (op)
        G1_ORA: begin
          nxt.acc = cur.acc | mem_data;
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
        G1_AND: begin
          nxt.acc = cur.acc & mem_data;
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
        G1_EOR: begin
          nxt.acc = cur.acc ^ mem_data;
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
        G1_ADC: begin
          nxt.acc = sum[DataW-1:0];
          nxt.c   = sum[DataW];
          nxt.v   = |((cur.acc ^ sum[DataW-1:0]) & (mem_data ^ sum[DataW-1:0]) & SignBit);
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
        G1_STA: begin
          // no store to an immediate
          ok = (mode != MODE_G1_IMM);
          we = ok;
          wd = cur.acc;
        end
        G1_LDA: begin
          nxt.acc = mem_data;
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
        G1_CMP: begin
          nxt.c = ~diff[DataW];
          nxt.z = (diff[DataW-1:0] == '0);
          nxt.n = diff[DataW-1];
        end
        default: begin
          nxt.acc = sbc[DataW-1:0];
          nxt.c   = ~sbc[DataW];
          nxt.v   = |((cur.acc ^ mem_data) & (cur.acc ^ sbc[DataW-1:0]) & SignBit);
          nxt.z   = (nxt.acc == '0);
          nxt.n   = nxt.acc[DataW-1];
        end
      endcase
    end else if (grp == GRP_2) begin
      if (mode == MODE_G2_BADA || mode == MODE_G2_BADB) begin
        ok = 1'b0;
      end else if (mode == MODE_G2_IMM && op != G2_LDX) begin
        ok = 1'b0;
      end else if (mode == MODE_G2_ACC) begin
        // only the shifts take accumulator mode
        if (op == G2_ASL || op == G2_ROL || op == G2_LSR || op == G2_ROR) begin
          ok      = 1'b1;
          nxt.acc = sha[DataW-1:0];
          nxt.c   = sha[DataW];
          nxt.z   = (sha[DataW-1:0] == '0);
          nxt.n   = sha[DataW-1];
        end
      end else begin
        ok = 1'b1;
        unique case (op)
          G2_ASL, G2_ROL, G2_LSR, G2_ROR: begin
            we    = 1'b1;
            wd    = shm[DataW-1:0];
            nxt.c = shm[DataW];
            nxt.z = (shm[DataW-1:0] == '0);
            nxt.n = shm[DataW-1];
          end
          G2_STX: begin
            we = 1'b1;
            wd = cur.xreg;
          end
          G2_LDX: begin
            nxt.xreg = mem_data;
            nxt.z    = (mem_data == '0);
            nxt.n    = mem_data[DataW-1];
          end
          G2_DEC: begin
            we    = 1'b1;
            wd    = dec_v;
            nxt.z = (dec_v == '0);
            nxt.n = dec_v[DataW-1];
          end
          default: begin
            we    = 1'b1;
            wd    = inc_v;
            nxt.z = (inc_v == '0);
            nxt.n = inc_v[DataW-1];
          end
        endcase
      end
    end
    // drop every side effect of an unrecognized code
    if (!ok) begin
      nxt = cur;
      we  = 1'b0;
      wd  = '0;
    end
  end

  always_comb begin
    res.recognized   = ok;
    res.write_enable = we;
    res.write_data   = we ? wd : '0;
    res.acc          = nxt.acc;
    res.xreg         = nxt.xreg;
    res.flags        = {nxt.n, nxt.v, nxt.z, nxt.c};
  end

endmodule

// ----- src/cpu8_outreg.sv -----
// Result register with valid/stall handshake on the output side.
module cpu8_outreg import cpu8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t load_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t data
);

  logic valid;

  assign out_valid = valid;
  assign full      = valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
